@@ hw/rtl/adrs_pkg.sv @@
`default_nettype none

package adrs_pkg;

    localparam int TIME_BITS    = 32;
    localparam int SAMPLE_BITS  = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_BITS     = 32;

    localparam logic [TIME_BITS-1:0] INTERVAL_RESET = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET  = TIME_BITS'(10000);

    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT  = CFG_IDX_BITS'(1);

    localparam logic [1:0] CH_VOLTAGE = 2'd2;
    localparam logic [1:0] CH_CURRENT = 2'd0;

    typedef enum logic [1:0] {
        PH_VOLTAGE = 2'd0,
        PH_CURRENT = 2'd1,
        PH_WAIT    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_REFUSED = 2'd2,
        ST_BUSY    = 2'd3
    } t_status;

    // input beat fields, last member in the lowest bits
    typedef struct packed {
        logic                   adc_accepts;
        logic [SAMPLE_BITS-1:0] adc_value;
        logic                   adc_has_value;
        logic [TIME_BITS-1:0]   now_time;
    } t_item;

    // result beat fields, last member in the lowest bits
    typedef struct packed {
        logic [1:0]             phase;
        logic [1:0]             status;
        logic [TIME_BITS-1:0]   record_time;
        logic [SAMPLE_BITS-1:0] record_current;
        logic [SAMPLE_BITS-1:0] record_voltage;
        logic                   record_valid;
        logic                   request_is_current;
        logic [1:0]             request_channel;
        logic                   request_valid;
    } t_result;

    localparam int ITEM_BITS   = $bits(t_item);
    localparam int RESULT_BITS = $bits(t_result);
    localparam int S_DATA_BITS = ((ITEM_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hw/rtl/dual_channel_adc_read_sequencer_top.sv @@
// channel | direction | handshake             | payload
// s       | in        | i_s_tvalid/o_s_tready | i_s_tdata, i_s_tuser (req_type)
// m       | out       | o_m_tvalid/i_m_tready | o_m_tdata
// cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// one beat per cycle sustained while m is ready; a beat reaches o_m_tdata through the
// input register, then the sequencing logic into the result register
// synchronous active-low reset: phase waiting, no result awaited, registers to defaults
// a stall on m holds the result register and backs up through the input register
// config port is always ready
`default_nettype none

module dual_channel_adc_read_sequencer_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // now_time[31:0], adc_has_value[32], adc_value[48:33], adc_accepts[49], zero pad
    input  wire logic [adrs_pkg::S_DATA_BITS-1:0]  i_s_tdata,
    // req_type[0]
    input  wire logic                              i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // request_valid[0], request_channel[2:1], request_is_current[3], record_valid[4],
    // record_voltage[20:5], record_current[36:21], record_time[68:37], status[70:69],
    // phase[72:71], zero pad
    output logic [adrs_pkg::M_DATA_BITS-1:0]       o_m_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [adrs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [adrs_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import adrs_pkg::*;

    logic    r_in_valid;
    logic    r_in_user;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    advance;

    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    adrs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (advance),
        .i_req_type  (r_in_user),
        .i_item      (r_in_item),
        .o_result    (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_in_user <= i_s_tuser;
            r_in_item <= t_item'(i_s_tdata[ITEM_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_BITS-RESULT_BITS){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ hw/rtl/adrs_core.sv @@
`default_nettype none

module adrs_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [adrs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [adrs_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  wire logic                           i_fire,
    input  wire logic                           i_req_type,
    input  wire adrs_pkg::t_item                i_item,
    output adrs_pkg::t_result                   o_result
);
    import adrs_pkg::*;

    logic [TIME_BITS-1:0]   r_interval, r_timeout;
    t_phase                 r_phase, n_phase;
    logic                   r_await, n_await;
    logic [TIME_BITS-1:0]   r_last, n_last;
    logic [TIME_BITS-1:0]   r_pend, n_pend;
    logic [SAMPLE_BITS-1:0] r_hv, n_hv;
    logic [SAMPLE_BITS-1:0] r_hc, n_hc;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS:0]     mean_sum;
    t_result                res;

    assign elapsed  = i_item.now_time - r_last;
    assign mean_sum = {1'b0, r_pend} + {1'b0, i_item.now_time};

    always_comb begin
        n_phase = r_phase;
        n_await = r_await;
        n_last  = r_last;
        n_pend  = r_pend;
        n_hv    = r_hv;
        n_hc    = r_hc;
        res     = '0;
        if (i_req_type) begin
            if (r_phase == PH_WAIT) begin
                n_phase = PH_VOLTAGE;
            end else begin
                res.status = ST_BUSY;
            end
        end else if (r_await) begin
            if (i_item.adc_has_value) begin
                if (r_phase == PH_VOLTAGE) begin
                    n_hv    = i_item.adc_value;
                    n_phase = PH_CURRENT;
                end else begin
                    n_hc               = i_item.adc_value;
                    n_phase            = PH_WAIT;
                    n_pend             = mean_sum[TIME_BITS:1];
                    res.record_valid   = 1'b1;
                    res.record_voltage = r_hv;
                    res.record_current = i_item.adc_value;
                    res.record_time    = mean_sum[TIME_BITS:1];
                end
                n_await = 1'b0;
            end else if (elapsed > r_timeout) begin
                res.status = ST_TIMEOUT;
                n_await    = 1'b0;
            end
        end else if (r_phase == PH_WAIT) begin
            if (elapsed > r_interval) begin
                n_phase = PH_VOLTAGE;
            end
        end else if (i_item.adc_accepts) begin
            res.request_valid      = 1'b1;
            res.request_channel    = (r_phase == PH_CURRENT) ? CH_CURRENT : CH_VOLTAGE;
            res.request_is_current = (r_phase == PH_CURRENT);
            n_last                 = i_item.now_time;
            n_pend                 = i_item.now_time;
            n_await                = 1'b1;
        end else begin
            res.status = ST_REFUSED;
        end
        res.phase = n_phase;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_timeout  <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INTERVAL: r_interval <= i_cfg_data[TIME_BITS-1:0];
                REG_TIMEOUT:  r_timeout  <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_await <= 1'b0;
            r_last  <= '0;
            r_pend  <= '0;
            r_hv    <= '0;
            r_hc    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_await <= n_await;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_hv    <= n_hv;
            r_hc    <= n_hc;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/adrs_checker.sv @@
`default_nettype none

module adrs_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [adrs_pkg::M_DATA_BITS-1:0]  o_m_tdata
);
    import adrs_pkg::*;

    t_result res;
    assign res = t_result'(o_m_tdata[RESULT_BITS-1:0]);

    // a record closes the cycle: back to waiting, no request, no error
    a_record_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res.record_valid) |->
            (res.phase == PH_WAIT && res.status == ST_OK && !res.request_valid))
        else $error("record beat with inconsistent phase or status");

    // request channel and range agree with the phase being measured
    a_request_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res.request_valid) |->
            (res.status == ST_OK && !res.record_valid &&
             ((res.phase == PH_CURRENT && res.request_channel == CH_CURRENT &&
               res.request_is_current) ||
              (res.phase == PH_VOLTAGE && res.request_channel == CH_VOLTAGE &&
               !res.request_is_current))))
        else $error("request beat with mismatched channel, range or phase");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result beat shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind dual_channel_adc_read_sequencer_top adrs_checker u_adrs_checker (.*);

`default_nettype wire

@@ tb/dual_channel_adc_read_sequencer_top_tb.sv @@
`default_nettype none

module dual_channel_adc_read_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adrs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CHUNK_ITEMS  = 130;
    localparam int BURST_ITEMS  = 40;
    localparam int MAX_PRINTS   = 100;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = '1;
    localparam logic [TIME_BITS-1:0]    TIME_MAX     = '1;

    localparam logic REQ_POLL   = 1'b0;
    localparam logic REQ_MANUAL = 1'b1;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_DATA_BITS-1:0]  i_s_tdata;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_DATA_BITS-1:0]  o_m_tdata;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;

    dual_channel_adc_read_sequencer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sequencer shadow state
    t_phase                 seq_phase;
    logic                   seq_awaiting;
    logic [TIME_BITS-1:0]   seq_last_req_time;
    logic [TIME_BITS-1:0]   seq_pending_time;
    logic [SAMPLE_BITS-1:0] seq_held_voltage;
    logic [SAMPLE_BITS-1:0] seq_held_current;
    logic [TIME_BITS-1:0]   cfg_interval;
    logic [TIME_BITS-1:0]   cfg_timeout;

    t_result expected_beats[$];

    int mismatches = 0;
    int cycles     = 0;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    logic [TIME_BITS-1:0] stim_time = '0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[RESULT_BITS-1:0]);
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with nothing expected", o_m_tdata[63:0], '0);
            end else begin
                want = expected_beats.pop_front();
                check_field("request_valid", 64'(got.request_valid),
                            64'(want.request_valid));
                check_field("request_channel", 64'(got.request_channel),
                            64'(want.request_channel));
                check_field("request_is_current", 64'(got.request_is_current),
                            64'(want.request_is_current));
                check_field("record_valid", 64'(got.record_valid),
                            64'(want.record_valid));
                check_field("record_voltage", 64'(got.record_voltage),
                            64'(want.record_voltage));
                check_field("record_current", 64'(got.record_current),
                            64'(want.record_current));
                check_field("record_time", 64'(got.record_time),
                            64'(want.record_time));
                check_field("status", 64'(got.status), 64'(want.status));
                check_field("phase", 64'(got.phase), 64'(want.phase));
            end
        end
    end

    task automatic sequence_step(input logic req, input t_item it);
        t_result              r;
        logic [TIME_BITS-1:0] elapsed;
        logic [TIME_BITS:0]   time_sum;
        r = '0;
        elapsed = it.now_time - seq_last_req_time;
        if (req == REQ_MANUAL) begin
            if (seq_phase == PH_WAIT)
                seq_phase = PH_VOLTAGE;
            else
                r.status = ST_BUSY;
        end else if (seq_awaiting) begin
            if (it.adc_has_value) begin
                if (seq_phase == PH_VOLTAGE) begin
                    seq_held_voltage = it.adc_value;
                    seq_phase = PH_CURRENT;
                end else begin
                    seq_held_current = it.adc_value;
                    seq_phase = PH_WAIT;
                    time_sum = {1'b0, seq_pending_time} + {1'b0, it.now_time};
                    seq_pending_time = time_sum[TIME_BITS:1];
                    r.record_valid = 1'b1;
                    r.record_voltage = seq_held_voltage;
                    r.record_current = seq_held_current;
                    r.record_time = seq_pending_time;
                end
                seq_awaiting = 1'b0;
            end else if (elapsed > cfg_timeout) begin
                r.status = ST_TIMEOUT;
                seq_awaiting = 1'b0;
            end
        end else if (seq_phase == PH_WAIT) begin
            if (elapsed > cfg_interval)
                seq_phase = PH_VOLTAGE;
        end else if (it.adc_accepts) begin
            r.request_valid = 1'b1;
            r.request_channel = (seq_phase == PH_CURRENT) ? CH_CURRENT : CH_VOLTAGE;
            r.request_is_current = (seq_phase == PH_CURRENT);
            seq_last_req_time = it.now_time;
            seq_pending_time = it.now_time;
            seq_awaiting = 1'b1;
        end else begin
            r.status = ST_REFUSED;
        end
        r.phase = seq_phase;
        expected_beats.push_back(r);
    endtask

    task automatic send_beat(input logic req, input t_item it);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= S_DATA_BITS'(it);
        i_s_tuser <= req;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sequence_step(req, it);
    endtask

    task automatic drain_pipeline();
        i_s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] data);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_INTERVAL)
            cfg_interval = data;
        else if (idx == REG_TIMEOUT)
            cfg_timeout = data;
    endtask

    function automatic t_item make_item(input logic [TIME_BITS-1:0] now,
                                        input logic has_value,
                                        input logic [SAMPLE_BITS-1:0] value,
                                        input logic accepts);
        t_item it;
        it.now_time = now;
        it.adc_has_value = has_value;
        it.adc_value = value;
        it.adc_accepts = accepts;
        return it;
    endfunction

    // mostly small time steps so that cycles complete, with rare far jumps and wraps
    task automatic send_random_beat();
        logic req;
        case ($urandom_range(0, 19))
            0:       stim_time = $urandom;
            1, 2, 3: stim_time = stim_time + $urandom_range(0, 12000);
            4, 5, 6: stim_time = stim_time + $urandom_range(0, 3500);
            default: stim_time = stim_time + $urandom_range(0, 60);
        endcase
        req = ($urandom_range(0, 99) < 8) ? REQ_MANUAL : REQ_POLL;
        send_beat(req, make_item(stim_time, $urandom_range(0, 99) < 35,
                                 SAMPLE_BITS'($urandom_range(0, 16'hFFFF)),
                                 $urandom_range(0, 99) < 70));
    endtask

    task automatic test_directed_sequence();
        send_beat(REQ_POLL, make_item(32'd0, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'd1000, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'd1001, 1'b0, 16'h0000, 1'b0));
        send_beat(REQ_POLL, make_item(32'd1002, 1'b0, 16'h0000, 1'b0));
        send_beat(REQ_MANUAL, make_item(32'd1003, 1'b0, 16'h0000, 1'b0));
        send_beat(REQ_POLL, make_item(32'd1004, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'd1005, 1'b1, 16'hFFFF, 1'b1));
        send_beat(REQ_POLL, make_item(32'd1006, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'd11006, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'd11007, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'hFFFF_FFF0, 1'b0, 16'h0000, 1'b1));
        // result after the time counter wrapped
        send_beat(REQ_POLL, make_item(32'h0000_0005, 1'b1, 16'h0000, 1'b0));
        send_beat(REQ_MANUAL, make_item(32'd6, 1'b0, 16'h0000, 1'b0));
        send_beat(REQ_MANUAL, make_item(32'd7, 1'b0, 16'h0000, 1'b0));
        send_beat(REQ_POLL, make_item(32'd8, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_MANUAL, make_item(32'd9, 1'b1, 16'hA5A5, 1'b1));
        send_beat(REQ_POLL, make_item(TIME_MAX, 1'b0, 16'h0000, 1'b0));
        send_beat(REQ_POLL, make_item(TIME_MAX, 1'b0, 16'h5A5A, 1'b1));
        send_beat(REQ_POLL, make_item(32'd0, 1'b1, 16'h5A5A, 1'b0));
        send_beat(REQ_POLL, make_item(32'd1, 1'b0, 16'h0000, 1'b1));
        send_beat(REQ_POLL, make_item(32'h7FFF_FFFF, 1'b1, 16'h8001, 1'b1));
        send_beat(REQ_POLL, make_item(32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b1));
        stim_time = 32'h7FFF_FFFF;
    endtask

    task automatic test_config_extremes();
        write_register(REG_INTERVAL, '0);
        write_register(REG_TIMEOUT, '0);
        write_register(REG_UNMAPPED, 32'h0000_0003);
        repeat (40) send_random_beat();
        write_register(REG_INTERVAL, '1);
        write_register(REG_TIMEOUT, '1);
        repeat (40) send_random_beat();
        write_register(REG_INTERVAL, INTERVAL_RESET);
        write_register(REG_TIMEOUT, TIMEOUT_RESET);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                       input int count);
        for (int i = 0; i < count; i++) begin
            if (i % CHUNK_ITEMS == 0) begin
                write_register(REG_INTERVAL, ($urandom_range(0, 7) == 0) ? 0 :
                                             $urandom_range(0, 3000));
                write_register(REG_TIMEOUT, $urandom_range(0, 6000));
            end
            if (i % BURST_ITEMS == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end else begin
                    s_idle_pct = sender_idle;
                    m_idle_pct = receiver_idle;
                end
            end
            send_random_beat();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        seq_phase = PH_WAIT;
        seq_awaiting = 1'b0;
        seq_last_req_time = '0;
        seq_pending_time = '0;
        seq_held_voltage = '0;
        seq_held_current = '0;
        cfg_interval = INTERVAL_RESET;
        cfg_timeout = TIMEOUT_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        s_idle_pct = 28;
        m_idle_pct = 80;
        test_directed_sequence();
        test_config_extremes();
        test_random_traffic(28, 80, RANDOM_ITEMS / 3);
        test_random_traffic(80, 28, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        drain_pipeline();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ dual_channel_adc_read_sequencer_top.f @@
hw/rtl/adrs_pkg.sv
hw/rtl/adrs_core.sv
hw/rtl/dual_channel_adc_read_sequencer_top.sv
hw/rtl/adrs_checker.sv
tb/dual_channel_adc_read_sequencer_top_tb.sv
